>>> rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiator.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic start;
    logic bypass;
  } mexp_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mexp_sts_t;

endpackage

>>> rtl/mexp_if.sv
// ----------------------------------------------------------------------------
// mexp_if
// Valid/ready channel interfaces for operands, results and the modulus.
// ----------------------------------------------------------------------------
interface mexp_in_if
  import mexp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] base;
  logic [DATA_W-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if
  import mexp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

interface mexp_cfg_if
  import mexp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface

>>> rtl/modular_exponentiator_top.sv
// ----------------------------------------------------------------------------
// modular_exponentiator_top
// Right-to-left binary modular exponentiation over a shared modular multiplier.
//
//   channel   dir  payload              transaction when
//   in_ch     in   base, exponent       valid & ready
//   out_ch    out  result               valid & ready
//   cfg_ch    in   modulus              valid & ready
//
// A modular multiply runs through launch, product, reduction steps of two
// product bits each and handoff; with a zero modulus it skips the reduction.
// in_ch.ready stays low during the work; a waiting result stalls only the
// next handoff. Reset restores the modulus to one.
// ----------------------------------------------------------------------------
module modular_exponentiator_top
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH    = 32,
  parameter int unsigned EXP_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  mexp_in_if.sink    in_ch,
  mexp_out_if.source out_ch,
  mexp_cfg_if.sink   cfg_ch
);

  localparam int unsigned EB = (EXP_BITS < DATA_W) ? EXP_BITS : DATA_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_STEP,
    S_MUL,
    S_SQR,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [WIDTH-1:0]  mod_r;
  logic [WIDTH-1:0]  pw_r;
  logic [WIDTH-1:0]  acc_r;
  logic [EB-1:0]     exp_r;
  logic [WIDTH-1:0]  op_a_r;
  logic [WIDTH-1:0]  op_b_r;
  logic              start_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] result_r;

  mexp_cmd_t         cmd;
  mexp_sts_t         sts;
  logic [WIDTH-1:0]  unit_res;

  assign cmd.start  = start_r;
  assign cmd.bypass = (mod_r == '0);

  mexp_mulred #(
    .WIDTH (WIDTH)
  ) u_mulred (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd_i (cmd),
    .a_i   (op_a_r),
    .b_i   (op_b_r),
    .mod_i (mod_r),
    .sts_o (sts),
    .res_o (unit_res)
  );

  assign in_ch.ready   = (state_r == S_IDLE) && !sts.busy;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= WIDTH'(1);
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= ((state_r == S_IDLE) && in_ch.valid && in_ch.ready) ||
                 ((state_r == S_STEP) && (exp_r != '0)) ||
                 ((state_r == S_MUL) && sts.done && ((exp_r >> 1) != '0));
      out_valid_r <= (state_r == S_DONE) || (out_valid_r && !out_ch.ready);
      if (cfg_ch.valid && cfg_ch.ready) begin
        mod_r <= cfg_ch.modulus[WIDTH-1:0];
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            pw_r    <= in_ch.base[WIDTH-1:0];
            exp_r   <= in_ch.exponent[EB-1:0];
            acc_r   <= (mod_r == WIDTH'(1)) ? '0 : WIDTH'(1);
            op_a_r  <= in_ch.base[WIDTH-1:0];
            op_b_r  <= WIDTH'(1);
            state_r <= S_BASE;
          end
        end
        S_BASE: begin
          if (sts.done) begin
            pw_r    <= unit_res;
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          if (exp_r == '0) begin
            state_r <= S_DONE;
          end else if (exp_r[0]) begin
            op_a_r  <= acc_r;
            op_b_r  <= pw_r;
            state_r <= S_MUL;
          end else begin
            op_a_r  <= pw_r;
            op_b_r  <= pw_r;
            state_r <= S_SQR;
          end
        end
        S_MUL: begin
          if (sts.done) begin
            acc_r <= unit_res;
            if ((exp_r >> 1) == '0) begin
              exp_r   <= '0;
              state_r <= S_STEP;
            end else begin
              op_a_r  <= pw_r;
              op_b_r  <= pw_r;
              state_r <= S_SQR;
            end
          end
        end
        S_SQR: begin
          if (sts.done) begin
            pw_r    <= unit_res;
            exp_r   <= exp_r >> 1;
            state_r <= S_STEP;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            result_r <= DATA_W'(acc_r);
            state_r  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/mexp_mulred.sv
// ----------------------------------------------------------------------------
// mexp_mulred
// Shared modular multiplier: one full-width product, then a restoring
// shift-subtract reduction (two product bits per cycle) unless modulus is 0.
// ----------------------------------------------------------------------------
module mexp_mulred
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mexp_cmd_t        cmd_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0] mod_i,
  output mexp_sts_t        sts_o,
  output logic [WIDTH-1:0] res_o
);

  localparam int unsigned PW = 2 * WIDTH;
  localparam int unsigned CW = $clog2(WIDTH);

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_RED
  } ustate_t;

  ustate_t          state_r;
  logic [WIDTH-1:0] opa_r;
  logic [WIDTH-1:0] opb_r;
  logic             byp_r;
  logic [PW-1:0]    prod_r;
  logic [PW-1:0]    prod_full;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] rem_nxt;
  logic [CW-1:0]    cnt_r;
  logic [WIDTH-1:0] res_r;
  logic             done_r;

  logic [WIDTH:0]   mod_ext;
  logic [WIDTH:0]   t1;
  logic [WIDTH:0]   t2;

  assign prod_full = opa_r * opb_r;
  assign mod_ext   = {1'b0, mod_i};

  always_comb begin
    t1 = {rem_r, prod_r[PW-1]};
    if (t1 >= mod_ext) begin
      t1 = t1 - mod_ext;
    end
    t2 = {t1[WIDTH-1:0], prod_r[PW-2]};
    if (t2 >= mod_ext) begin
      t2 = t2 - mod_ext;
    end
    rem_nxt = t2[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= ((state_r == U_MUL) && byp_r) || ((state_r == U_RED) && (cnt_r == '0));
      case (state_r)
        U_IDLE: begin
          if (cmd_i.start) begin
            opa_r   <= a_i;
            opb_r   <= b_i;
            byp_r   <= cmd_i.bypass;
            state_r <= U_MUL;
          end
        end
        U_MUL: begin
          prod_r <= prod_full;
          rem_r  <= '0;
          cnt_r  <= CW'(WIDTH - 1);
          if (byp_r) begin
            res_r   <= prod_full[WIDTH-1:0];
            state_r <= U_IDLE;
          end else begin
            state_r <= U_RED;
          end
        end
        U_RED: begin
          rem_r  <= rem_nxt;
          prod_r <= prod_r << 2;
          if (cnt_r == '0) begin
            res_r   <= rem_nxt;
            state_r <= U_IDLE;
          end else begin
            cnt_r <= cnt_r - CW'(1);
          end
        end
        default: begin
          state_r <= U_IDLE;
        end
      endcase
    end
  end

  assign sts_o.busy = (state_r != U_IDLE);
  assign sts_o.done = done_r;
  assign res_o      = res_r;

endmodule

>>> rtl/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level assertions for the modular exponentiator, bound to the top.
// ----------------------------------------------------------------------------
module mexp_checker
  import mexp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_result
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready ##1 !in_ready)
    else $error("operands taken while a transaction is in work");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result shown without work behind it");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left a result or a busy state");

endmodule

bind modular_exponentiator_top mexp_checker u_mexp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_result (out_ch.result)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for modular_exponentiator_top. A walk through a table of
// directed operands (modulus of one, zero exponent, wrap-around modulus,
// extreme bases and exponents) is followed by phases of random operands under
// different moduli. Every result is matched in order against the table's
// expected value or a square-and-multiply predictor, with random gaps on the
// operand side and random back-pressure on the result side, not in phase 2.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT  = 6000000;
  localparam int unsigned SETTLE       = 2400;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_ITEMS  = 37;
  localparam int unsigned NUM_DIRECTED = 22;

  typedef struct packed {
    logic [31:0] modulus;
    logic [31:0] base;
    logic [31:0] exponent;
    logic        known;
    logic [31:0] want;
  } directed_vec_t;

  localparam directed_vec_t DIRECTED [NUM_DIRECTED] = '{
    '{32'h0000_0001, 32'h0000_0005, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0001, 1'b1, 32'hFFFF_FFFE},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0002, 1'b1, 32'h0000_0001},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE},
    '{32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_001F, 1'b1, 32'h8000_0000},
    '{32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0020, 1'b1, 32'h0000_0001},
    '{32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{32'h0000_0000, 32'h0000_0002, 32'h0000_0020, 1'b1, 32'h0000_0000},
    '{32'h0000_0000, 32'h0000_0003, 32'h0000_0000, 1'b1, 32'h0000_0001},
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 1'b1, 32'h8000_0000},
    '{32'h0000_0000, 32'hA5C3_9E17, 32'h8765_4321, 1'b0, 32'h0000_0000},
    '{32'h0000_0002, 32'h0000_0007, 32'h0000_0005, 1'b1, 32'h0000_0001},
    '{32'h0000_0002, 32'h0000_0006, 32'h0000_0003, 1'b1, 32'h0000_0000},
    '{32'h0000_0002, 32'h0000_0009, 32'h0000_0000, 1'b1, 32'h0000_0001},
    '{32'hFFFF_FFFB, 32'hDEAD_BEEF, 32'hFFFF_FFFA, 1'b1, 32'h0000_0001},
    '{32'hFFFF_FFFB, 32'hFFFF_FFFB, 32'h0000_0005, 1'b1, 32'h0000_0000},
    '{32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000}
  };

  logic clk;
  logic rst_n;

  mexp_in_if  in_if ();
  mexp_out_if out_if ();
  mexp_cfg_if cfg_if ();

  modular_exponentiator_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  logic [31:0] pending_results [$];
  logic [31:0] cur_modulus;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          quiet;

  always #5 clk = ~clk;

  function automatic logic [31:0] mod_reduce(input logic [63:0] x, input logic [31:0] m);
    if (m == 32'd0) begin
      return x[31:0];
    end
    return 32'(x % {32'd0, m});
  endfunction

  function automatic logic [31:0] mod_power(input logic [31:0] b, input logic [31:0] e,
                                            input logic [31:0] m);
    logic [31:0] pw;
    logic [31:0] acc;
    pw  = mod_reduce({32'd0, b}, m);
    acc = mod_reduce(64'd1, m);
    for (int i = 0; i < 32; i++) begin
      if (e[i]) begin
        acc = mod_reduce({32'd0, acc} * {32'd0, pw}, m);
      end
      pw = mod_reduce({32'd0, pw} * {32'd0, pw}, m);
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic set_modulus(input logic [31:0] m);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.modulus <= m;
    do @(posedge clk); while (!cfg_if.ready);
    cur_modulus = m;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_operands(input logic [31:0] b, input logic [31:0] e, input bit known,
                               input logic [31:0] want);
    while (!quiet && $urandom_range(99) < 16) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.base     <= b;
    in_if.exponent <= e;
    do @(posedge clk); while (!in_if.ready);
    pending_results = {pending_results, (known ? want : mod_power(b, e, cur_modulus))};
  endtask

  always @(posedge clk) begin
    out_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_if.result, 32'd0);
      end else begin
        logic [31:0] want;
        want = pending_results.pop_front();
        if (out_if.result !== want) begin
          report_mismatch("result", out_if.result, want);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] m;
    logic [31:0] b;
    logic [31:0] e;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.base      = '0;
    in_if.exponent  = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.modulus  = '0;
    cur_modulus     = 32'd1;
    quiet           = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (i != 0 && DIRECTED[i].modulus != DIRECTED[i-1].modulus) begin
        set_modulus(DIRECTED[i].modulus);
      end
      send_operands(DIRECTED[i].base, DIRECTED[i].exponent, DIRECTED[i].known,
                    DIRECTED[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       m = $urandom;
        1:       m = 32'hFFFF_FFFF;
        2:       m = $urandom_range(2, 1000);
        3:       m = 32'd0;
        4:       m = $urandom | 32'h8000_0001;
        5:       m = 32'd1;
        default: m = 32'd1 << $urandom_range(1, 31);
      endcase
      set_modulus(m);
      quiet = (p == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0:       b = 32'd0;
          1:       b = cur_modulus - 32'd1;
          2:       b = $urandom_range(0, 15);
          default: b = $urandom;
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3: e = $urandom;
          4, 5:       e = $urandom_range(0, 255);
          6:          e = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
          default:    e = $urandom >> $urandom_range(0, 31);
        endcase
        send_operands(b, e, 1'b0, 32'd0);
      end
      quiet = 1'b0;
    end

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
